// ===== src/ple_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ple_pkg
// Shared types and constants for the position list engine: command and
// status codes, field widths and the control bundle of the entry cells.
// ============================================================================
package ple_pkg;

    // Field widths of the request and response channels.
    localparam int ENTRY_W = 32;
    localparam int CMD_W   = 2;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;

    // Default number of entry cells.
    localparam int CAPACITY_DEFAULT = 64;

    typedef logic signed [ENTRY_W-1:0] t_entry;

    // Entry returned by a read at a bad position (all ones, that is -1).
    localparam t_entry ENTRY_FAIL = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_FIND   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What the whole row of cells does in one cycle.
    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_ROTATE = 2'd3
    } t_cell_mode;

    // Broadcast to every cell.
    typedef struct packed {
        t_cell_mode mode;
        t_entry     value;
    } t_cell_ctrl;

    // Position flags that are particular to one cell.
    typedef struct packed {
        logic at_pos;
        logic above_pos;
        logic at_last;
        logic below_last;
    } t_cell_sel;

endpackage

// ===== src/ple_cmd_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ple_cmd_if
// Request channel of the position list engine: command, position and value.
// ============================================================================
interface ple_cmd_if;
    import ple_pkg::*;

    logic                 valid;
    logic                 ready;
    t_cmd                 command;
    logic [POS_W-1:0]     position;
    logic signed [ENTRY_W-1:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink (input valid, input command, input position, input value,
                  output ready);
endinterface

// ===== src/ple_rsp_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ple_rsp_if
// Response channel of the position list engine: status, entry, match
// position and list length after the request.
// ============================================================================
interface ple_rsp_if;
    import ple_pkg::*;

    logic                      valid;
    logic                      ready;
    t_status                   status;
    logic signed [ENTRY_W-1:0] entry_out;
    logic [POS_W-1:0]          found_position;
    logic [POS_W-1:0]          list_length;

    modport source (output valid, output status, output entry_out,
                    output found_position, output list_length, input ready);
    modport sink (input valid, input status, input entry_out,
                  input found_position, input list_length, output ready);
endinterface

// ===== src/ple_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ple_cell
// One list entry. Depending on the row mode it keeps its entry, loads the
// inserted value, or takes the entry of the cell below, the cell above or
// the head cell.
// ============================================================================
module ple_cell (
    input  logic               i_clk,
    input  ple_pkg::t_cell_ctrl i_ctrl,
    input  ple_pkg::t_cell_sel  i_sel,
    input  ple_pkg::t_entry     i_up,
    input  ple_pkg::t_entry     i_down,
    input  ple_pkg::t_entry     i_head,
    output ple_pkg::t_entry     o_entry
);
    import ple_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Select the next entry from the row mode and this cell's place.
    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.mode)
            MODE_HOLD: begin
                n_entry = r_entry;
            end
            MODE_INSERT: begin
                // The inserted value lands here; later entries move up.
                if (i_sel.at_pos) begin
                    n_entry = i_ctrl.value;
                end else if (i_sel.above_pos) begin
                    n_entry = i_down;
                end
            end
            MODE_DELETE: begin
                // The entry at the position is dropped; later entries move down.
                if (i_sel.at_pos || i_sel.above_pos) begin
                    n_entry = i_up;
                end
            end
            MODE_ROTATE: begin
                // Occupied cells rotate toward the head; the last takes the head.
                if (i_sel.below_last) begin
                    n_entry = i_up;
                end else if (i_sel.at_last) begin
                    n_entry = i_head;
                end
            end
        endcase
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== src/position_list_engine.sv =====
`timescale 1ns / 1ps
// ============================================================================
// position_list_engine
// Packed list of signed 32-bit entries with insert, delete, read and find
// by 1-based position, built as a row of entry cells.
// ============================================================================
// The list lives in a row of CAPACITY cells, one entry each, and the block
// handles one request at a time. An insert, and any request that fails its
// position or full check, goes from S_EXEC straight to S_FINISH. Read, find
// and delete run a pass over the count entries, where count is the list
// length when the request arrives: the occupied cells rotate past the head
// cell one entry per cycle, so each entry is seen once and the row is back
// in order when the pass ends; a delete then shifts the later entries down
// in S_SHIFT. A find on an empty list skips the pass. A response waits in
// an output register, and the next request is accepted while it waits.
// There is no clearing pass after reset.
module position_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
    input logic      i_clk,
    input logic      i_rst_n,
    ple_cmd_if.sink  i_cmd,
    ple_rsp_if.source o_rsp
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_step;
    t_cmd               r_cmd;
    logic [POS_W-1:0]   r_pos;
    t_entry             r_value;
    t_status            r_status;
    t_entry             r_ent;
    logic               r_found;
    logic [POS_W-1:0]   r_fpos;
    logic               r_ovalid;
    t_status            r_ostatus;
    t_entry             r_oent;
    logic [POS_W-1:0]   r_ofpos;
    logic [POS_W-1:0]   r_olen;

    logic [CMP_W-1:0]   w_pos_ext;
    logic [CMP_W-1:0]   w_cnt_ext;
    logic [CMP_W-1:0]   w_pos_idx;
    logic [CMP_W-1:0]   w_cnt_m1;
    logic               w_bad_ins;
    logic               w_bad_pos;
    logic               w_full;
    logic               w_last_step;
    logic               w_at_step;
    logic               w_out_free;
    logic               w_load;
    t_entry             w_head;
    t_cell_ctrl         w_ctrl;
    t_entry             w_entry [CAPACITY];

    // Position and length checks on the held request.
    assign w_pos_ext   = CMP_W'(r_pos);
    assign w_cnt_ext   = CMP_W'(r_count);
    assign w_pos_idx   = w_pos_ext - CMP_W'(1);
    assign w_cnt_m1    = w_cnt_ext - CMP_W'(1);
    assign w_bad_ins   = (r_pos == '0) || (w_pos_ext > (w_cnt_ext + CMP_W'(1)));
    assign w_bad_pos   = (r_pos == '0) || (w_pos_ext > w_cnt_ext);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_last_step = (CMP_W'(r_step) == w_cnt_m1);
    assign w_at_step   = (CMP_W'(r_step) == w_pos_idx);
    assign w_out_free  = !r_ovalid || o_rsp.ready;
    assign w_load      = (r_state == S_FINISH) && w_out_free;
    assign w_head      = w_entry[0];

    // Row mode for this cycle.
    always_comb begin
        w_ctrl.value = r_value;
        w_ctrl.mode  = MODE_HOLD;
        unique case (r_state)
            S_EXEC: begin
                if ((r_cmd == CMD_INSERT) && !w_bad_ins && !w_full) begin
                    w_ctrl.mode = MODE_INSERT;
                end
            end
            S_SCAN:  w_ctrl.mode = MODE_ROTATE;
            S_SHIFT: w_ctrl.mode = MODE_DELETE;
            default: w_ctrl.mode = MODE_HOLD;
        endcase
    end

    // Row of entry cells, each wired to its neighbors and the head.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        localparam logic [CMP_W-1:0] K = CMP_W'(k);
        t_cell_sel w_sel;
        t_entry    w_up;
        t_entry    w_down;

        assign w_sel.at_pos     = (K == w_pos_idx);
        assign w_sel.above_pos  = (K > w_pos_idx);
        assign w_sel.at_last    = (K == w_cnt_m1);
        assign w_sel.below_last = (K < w_cnt_m1);
        assign w_up   = (k == CAPACITY - 1) ? w_entry[k] : w_entry[(k + 1) % CAPACITY];
        assign w_down = (k == 0) ? w_entry[k] : w_entry[(k + CAPACITY - 1) % CAPACITY];

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_sel   (w_sel),
            .i_up    (w_up),
            .i_down  (w_down),
            .i_head  (w_head),
            .o_entry (w_entry[k])
        );
    end

    // Request sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= i_cmd.command;
                        r_pos   <= i_cmd.position;
                        r_value <= i_cmd.value;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status <= ST_OK;
                    r_ent    <= '0;
                    r_found  <= 1'b0;
                    r_fpos   <= '0;
                    r_step   <= '0;
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            if (w_bad_ins) begin
                                r_status <= ST_RANGE;
                            end else if (w_full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            r_state <= S_FINISH;
                        end
                        CMD_DELETE, CMD_READ: begin
                            if (w_bad_pos) begin
                                r_status <= ST_RANGE;
                                if (r_cmd == CMD_READ) begin
                                    r_ent <= ENTRY_FAIL;
                                end
                                r_state <= S_FINISH;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        CMD_FIND: begin
                            r_state <= (r_count == '0) ? S_FINISH : S_SCAN;
                        end
                    endcase
                end
                S_SCAN: begin
                    // The head cell holds the entry at the current step.
                    r_step <= r_step + CNT_W'(1);
                    if ((r_cmd != CMD_FIND) && w_at_step) begin
                        r_ent <= w_head;
                    end
                    if ((r_cmd == CMD_FIND) && !r_found && (w_head == r_value)) begin
                        r_found <= 1'b1;
                        r_fpos  <= POS_W'(r_step + CNT_W'(1));
                    end
                    if (w_last_step) begin
                        r_state <= (r_cmd == CMD_DELETE) ? S_SHIFT : S_FINISH;
                    end
                end
                S_SHIFT: begin
                    r_count <= r_count - CNT_W'(1);
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Response register: loads when a request completes, clears once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid  <= 1'b1;
            r_ostatus <= r_status;
            r_oent    <= r_ent;
            r_ofpos   <= r_fpos;
            r_olen    <= POS_W'(r_count);
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign i_cmd.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.status         = r_ostatus;
    assign o_rsp.entry_out      = r_oent;
    assign o_rsp.found_position = r_ofpos;
    assign o_rsp.list_length    = r_olen;

    // The length never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list length exceeds capacity");

    // The rotation pass stays inside the occupied cells.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_step < r_count))
        else $error("scan step beyond list length");

    // An accepted request is evaluated in the next cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state == S_EXEC))
        else $error("accepted request not evaluated");

    // A full status is only reported while every cell is occupied.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && w_out_free && (r_status == ST_FULL))
            |-> (r_count == CNT_W'(CAPACITY)))
        else $error("full status with free cells");

    // A delete removes exactly one entry.
    a_delete_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("delete did not shorten the list by one");

endmodule
